FILE: rtl/cscm_pkg.sv
// cscm_pkg: item types, mode and range codes, key codes and register map
// for the cruise speed mode controller. No dependencies.

package cscm_pkg;

   // configuration register map
   localparam int unsigned CSR_COUNT     = 7;
   localparam int unsigned CSR_IDX_WIDTH = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FAR_UPPER    = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FAR_LOWER    = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MEDIUM_UPPER = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MEDIUM_LOWER = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CLOSE_UPPER  = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CLOSE_LOWER  = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DANGER       = 3'd6;

   typedef logic [CSR_COUNT-1:0][7:0] csr_bank_type;

   // reset values, index 0 in the low byte
   localparam csr_bank_type CSR_RESET = {8'd10, 8'd20, 8'd25, 8'd30, 8'd40, 8'd50, 8'd60};

   // key codes (ascii)
   localparam logic [7:0] KEY_ACCEL    = 8'h41; // A
   localparam logic [7:0] KEY_DECEL    = 8'h44; // D
   localparam logic [7:0] KEY_STOP     = 8'h53; // S
   localparam logic [7:0] KEY_OFF      = 8'h4F; // O
   localparam logic [7:0] KEY_NORMAL   = 8'h4E; // N
   localparam logic [7:0] KEY_ADAPTIVE = 8'h50; // P
   localparam logic [7:0] KEY_CLOSE    = 8'h43; // C
   localparam logic [7:0] KEY_MEDIUM   = 8'h4D; // M
   localparam logic [7:0] KEY_FAR      = 8'h46; // F

   // item command
   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // level limits and motor hysteresis
   localparam logic signed [8:0] LEVEL_MAX      = 9'sd100;
   localparam logic signed [8:0] LEVEL_MIN      = 9'sd10;
   localparam logic signed [8:0] LEVEL_MOTOR_ON = 9'sd15;
   localparam logic signed [8:0] KEY_STEP       = 9'sd5;
   localparam logic [13:0]       DUTY_SCALE     = 14'd100;

   typedef enum logic [1:0] {
      MODE_OFF      = 2'd0,
      MODE_NORMAL   = 2'd1,
      MODE_ADAPTIVE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      RANGE_NONE   = 2'd0,
      RANGE_CLOSE  = 2'd1,
      RANGE_MEDIUM = 2'd2,
      RANGE_FAR    = 2'd3
   } range_type;

   typedef struct packed {
      logic        command;
      logic [7:0]  key_code;
      logic [15:0] distance;
   } req_type;

   typedef struct packed {
      logic signed [7:0] level_now;
      logic [5:0]        shown_speed;
      logic [13:0]       duty_compare;
      logic              motor_on;
      logic [1:0]        cruise_mode_out;
      logic [7:0]        set_speed_out;
   } rsp_type;

   // controller state carried between items
   typedef struct packed {
      logic signed [7:0] level;
      mode_type          mode;
      logic [7:0]        set_speed;
      range_type         pending;
      logic [7:0]        upper_gap;
      logic [7:0]        lower_gap;
      logic              motor;
      logic [5:0]        shown;
      logic [13:0]       compare;
   } ctl_state_type;

endpackage

FILE: rtl/cscm_step.sv
// cscm_step: next controller state for one key or tick item.
// Depends on cscm_pkg.

module cscm_step (
   input  cscm_pkg::ctl_state_type state_cur,
   input  cscm_pkg::req_type       item,
   input  cscm_pkg::csr_bank_type  csr,
   output cscm_pkg::ctl_state_type state_nxt
);
   import cscm_pkg::*;

   // add a small step to the level, saturating at the 8-bit signed range
   function automatic logic signed [7:0] sat_step(input logic signed [7:0] v,
                                                   input logic signed [8:0] d);
      logic signed [8:0] s;
      begin
         s = {v[7], v} + d;
         if (s > 9'sd127) begin
            sat_step = 8'sd127;
         end else if (s < -9'sd128) begin
            sat_step = -8'sd128;
         end else begin
            sat_step = s[7:0];
         end
      end
   endfunction

   ctl_state_type     st;
   logic signed [8:0] lvl;
   logic signed [8:0] set9;
   logic [15:0]       danger;
   logic [15:0]       upper16;
   logic [15:0]       lower16;
   logic [6:0]        lvl_u;

   always_comb begin
      st      = state_cur;
      set9    = $signed({1'b0, state_cur.set_speed});
      danger  = {8'd0, csr[CSR_DANGER]};
      upper16 = '0;
      lower16 = '0;
      lvl     = '0;
      lvl_u   = '0;

      if (item.command == CMD_KEY) begin
         // key handling
         unique case (item.key_code)
            KEY_ACCEL: begin
               if (state_cur.mode == MODE_OFF ||
                   $signed({state_cur.level[7], state_cur.level}) < set9) begin
                  st.level = sat_step(state_cur.level, KEY_STEP);
               end
            end
            KEY_DECEL: begin
               if (state_cur.mode == MODE_ADAPTIVE) begin
                  st.mode = MODE_NORMAL;
               end
               st.level = sat_step(state_cur.level, -KEY_STEP);
            end
            KEY_STOP: begin
               st.mode  = MODE_OFF;
               st.level = '0;
            end
            KEY_OFF: begin
               st.mode = MODE_OFF;
            end
            KEY_NORMAL: begin
               st.mode      = MODE_NORMAL;
               st.set_speed = state_cur.level;
            end
            KEY_ADAPTIVE: begin
               st.mode      = MODE_ADAPTIVE;
               st.set_speed = state_cur.level;
            end
            KEY_CLOSE:  st.pending = RANGE_CLOSE;
            KEY_MEDIUM: st.pending = RANGE_MEDIUM;
            KEY_FAR:    st.pending = RANGE_FAR;
            default: begin
            end
         endcase
      end else begin
         // mode step
         if (state_cur.mode == MODE_ADAPTIVE) begin
            // take the queued gap range, if any
            unique case (state_cur.pending)
               RANGE_FAR: begin
                  st.upper_gap = csr[CSR_FAR_UPPER];
                  st.lower_gap = csr[CSR_FAR_LOWER];
               end
               RANGE_MEDIUM: begin
                  st.upper_gap = csr[CSR_MEDIUM_UPPER];
                  st.lower_gap = csr[CSR_MEDIUM_LOWER];
               end
               RANGE_CLOSE: begin
                  st.upper_gap = csr[CSR_CLOSE_UPPER];
                  st.lower_gap = csr[CSR_CLOSE_LOWER];
               end
               default: begin
               end
            endcase
            st.pending = RANGE_NONE;
            upper16    = {8'd0, st.upper_gap};
            lower16    = {8'd0, st.lower_gap};

            // steer by distance, then cap at the set speed
            priority if (item.distance > upper16) begin
               st.level = sat_step(state_cur.level, 9'sd1);
            end else if (item.distance < lower16 && item.distance > danger) begin
               st.level = sat_step(state_cur.level, -9'sd1);
            end else if (item.distance <= danger) begin
               st.level = LEVEL_MIN[7:0];
               st.mode  = MODE_OFF;
            end else begin
               // distance inside the gap window: level holds
            end
            if ($signed({st.level[7], st.level}) > set9) begin
               st.level = set9[7:0];
            end
         end else if (state_cur.mode == MODE_NORMAL) begin
            // cap first, then the danger check
            if ($signed({st.level[7], st.level}) > set9) begin
               st.level = set9[7:0];
            end
            if (item.distance <= danger) begin
               st.level = LEVEL_MIN[7:0];
               st.mode  = MODE_OFF;
            end
         end

         // speed step: clamp and motor hysteresis
         lvl = {st.level[7], st.level};
         priority if (lvl >= LEVEL_MAX) begin
            lvl = LEVEL_MAX;
         end else if (lvl <= LEVEL_MIN) begin
            st.motor = 1'b0;
            lvl      = LEVEL_MIN;
         end else if (lvl >= LEVEL_MOTOR_ON) begin
            st.motor = 1'b1;
         end else begin
            // inside the hysteresis band: motor keeps its state
         end
         st.level   = lvl[7:0];
         lvl_u      = lvl[6:0];
         st.shown   = 6'((lvl_u - LEVEL_MIN[6:0]) >> 1);
         st.compare = 14'({7'd0, lvl_u} * DUTY_SCALE - 14'd1);
      end
      state_nxt = st;
   end

endmodule

FILE: rtl/cruise_speed_mode_controller_core.sv
// cruise_speed_mode_controller_core: top level, input register, state and
// result register, gap registers. Depends on cscm_pkg and cscm_step.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | cscm_pkg::req_type
//   rsp_    | out       | rsp_valid/rsp_stall | cscm_pkg::rsp_type
//   csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// one item per cycle sustained while rsp_ is not stalled; an accepted item passes
// through the input register, then the state and result register.
// the whole step for an item is one pass of cscm_step between those registers.
// reset is synchronous and restores state, modes and the gap registers.
// a stall on rsp_ holds the result; req_stall rises only while the input
// register is full and cannot move on. csr_ is always ready.

module cruise_speed_mode_controller_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  cscm_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output cscm_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cscm_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [7:0]                            csr_wdata
);
   import cscm_pkg::*;

   logic          in_valid_ff;
   req_type       in_item_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_item_ff;
   ctl_state_type state_ff;
   ctl_state_type state_in;
   csr_bank_type  csr_ff;
   logic          proc;

   // item moves into the result register when that is free or being taken
   assign proc      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !proc;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // gap registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_valid && csr_ready && csr_index < CSR_IDX_WIDTH'(CSR_COUNT)) begin
         csr_ff[csr_index] <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
   end

   // next state for the item in the input register
   cscm_step u_step (
      .state_cur (state_ff),
      .item      (in_item_ff),
      .csr       (csr_ff),
      .state_nxt (state_in)
   );

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{level: '0, mode: MODE_OFF, set_speed: '0, pending: RANGE_NONE,
                       upper_gap: '0, lower_gap: '0, motor: 1'b0, shown: '0,
                       compare: '0};
      end else if (proc) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         rsp_item_ff.level_now       <= state_in.level;
         rsp_item_ff.shown_speed     <= state_in.shown;
         rsp_item_ff.duty_compare    <= state_in.compare;
         rsp_item_ff.motor_on        <= state_in.motor;
         rsp_item_ff.cruise_mode_out <= state_in.mode;
         rsp_item_ff.set_speed_out   <= state_in.set_speed;
      end
   end

   // a tick always leaves the level inside 10..100
   assert property (@(posedge clock) disable iff (reset)
      (proc && in_item_ff.command == CMD_TICK) |=>
         (state_ff.level >= 8'sd10 && state_ff.level <= 8'sd100))
      else $error("level outside 10..100 after a tick");

   // an adaptive tick consumes the queued range
   assert property (@(posedge clock) disable iff (reset)
      (proc && in_item_ff.command == CMD_TICK && state_ff.mode == MODE_ADAPTIVE) |=>
         (state_ff.pending == RANGE_NONE))
      else $error("queued range left after an adaptive tick");

   // the input side stalls only while an item waits in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked item");

   // a processed item always yields a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      proc |=> rsp_valid)
      else $error("processed item produced no result");

endmodule
